// ===== hw/rtl/rhythm_seed_drift_control_core_defines.svh =====
// ----------------------------------------------------------------------------
// rhythm_seed_drift_control_core_defines.svh
// Assertion macros used by the seed drift control sequencer (rsdc_ctrl).
// ----------------------------------------------------------------------------
`ifndef RHYTHM_SEED_DRIFT_CONTROL_CORE_DEFINES_SVH
`define RHYTHM_SEED_DRIFT_CONTROL_CORE_DEFINES_SVH
`ifndef SYNTH
`define RSDC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsdc assertion failed");
`define RSDC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsdc assertion failed");
`else
`define RSDC_ASSERT_IMP(label, clk, rst, ante, cons)
`define RSDC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/rsdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsdc_pkg
// Types, codes and constants for the rhythm seed drift control block.
// ----------------------------------------------------------------------------
package rsdc_pkg;

   localparam int MAX_STEPS_DEF = 32;

   localparam logic [31:0] GOLDEN   = 32'h9e3779b9;
   localparam logic [31:0] MIX_MUL1 = 32'h85ebca6b;
   localparam logic [31:0] MIX_MUL2 = 32'hc2b2ae35;

   localparam logic [5:0]  LEN_RST  = 6'd32;
   localparam logic [53:0] LVL_RST  = 54'd0;
   localparam logic [31:0] DSEED_RST = 32'd1;
   localparam logic [31:0] PXOR_RST = 32'd0;

   localparam logic [1:0] REG_LEN   = 2'd0;
   localparam logic [1:0] REG_LVL   = 2'd1;
   localparam logic [1:0] REG_DSEED = 2'd2;
   localparam logic [1:0] REG_PXOR  = 2'd3;

   localparam logic [2:0] FN_QUERY = 3'd0;
   localparam logic [2:0] FN_PEND  = 3'd1;
   localparam logic [2:0] FN_REQ   = 3'd2;
   localparam logic [2:0] FN_RESEED = 3'd3;
   localparam logic [2:0] FN_INIT  = 3'd4;
   localparam logic [2:0] FN_MASK  = 3'd5;

   localparam logic [2:0] CL_DOWN = 3'd0;
   localparam logic [2:0] CL_HALF = 3'd1;
   localparam logic [2:0] CL_QTR  = 3'd2;
   localparam logic [2:0] CL_8TH  = 3'd3;
   localparam logic [2:0] CL_16TH = 3'd4;
   localparam logic [2:0] CL_OFF  = 3'd5;

   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_LOAD = 4'd1;
   localparam logic [3:0] OP_DIV  = 4'd2;
   localparam logic [3:0] OP_QFIN = 4'd3;
   localparam logic [3:0] OP_MBIT = 4'd4;
   localparam logic [3:0] OP_MULC = 4'd5;
   localparam logic [3:0] OP_MIX1 = 4'd6;
   localparam logic [3:0] OP_MUL1 = 4'd7;
   localparam logic [3:0] OP_MIX2 = 4'd8;
   localparam logic [3:0] OP_MUL2 = 4'd9;
   localparam logic [3:0] OP_MIX3 = 4'd10;
   localparam logic [3:0] OP_PEA  = 4'd11;
   localparam logic [3:0] OP_RSA  = 4'd12;
   localparam logic [3:0] OP_COMB = 4'd13;
   localparam logic [3:0] OP_REQ  = 4'd14;
   localparam logic [3:0] OP_INIT = 4'd15;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       pending;
      logic       nseed_zero;
      logic       div_done;
      logic       mask_last;
      logic       mask_empty;
   } stat_type;

   function automatic logic [2:0] class_of(input logic [4:0] n);
      logic [2:0] c;
      if (n == 5'd0)                     c = CL_DOWN;
      else if (n == 5'd16)               c = CL_HALF;
      else if (n == 5'd8 || n == 5'd24)  c = CL_QTR;
      else if (n[2:0] == 3'd4)           c = CL_8TH;
      else if (n[0] == 1'b0)             c = CL_16TH;
      else                               c = CL_OFF;
      return c;
   endfunction

   function automatic logic [8:0] level_sel(input logic [53:0] lv, input logic [2:0] c);
      logic [8:0] l;
      case (c)
         CL_DOWN: l = lv[8:0];
         CL_HALF: l = lv[17:9];
         CL_QTR:  l = lv[26:18];
         CL_8TH:  l = lv[35:27];
         CL_16TH: l = lv[44:36];
         default: l = lv[53:45];
      endcase
      return l;
   endfunction

endpackage

// ===== hw/rtl/rsdc_div.sv =====
// ----------------------------------------------------------------------------
// rsdc_div
// Restoring divider, one quotient bit per cycle, for the step rescale.
// ----------------------------------------------------------------------------
module rsdc_div
   import rsdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [10:0] dividend,
   input  logic [5:0]  divisor,
   output logic [10:0] quotient,
   output logic        done
);
   localparam int NBITS = 11;
   localparam int CW = $clog2(NBITS);

   logic [10:0]   quo_ff, quo_in;
   logic [5:0]    rem_ff, rem_in;
   logic [5:0]    dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [6:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[10]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = 6'd0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 6'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[9:0], 1'b1};
         end else begin
            rem_in = trial[5:0];
            quo_in = {quo_ff[9:0], 1'b0};
         end
         cnt_in = CW'(cnt_ff + 1'b1);
         if (cnt_ff == CW'(NBITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== hw/rtl/rsdc_dp.sv =====
// ----------------------------------------------------------------------------
// rsdc_dp
// Datapath: seed state, shared multiplier, hash combine, step classifier.
// ----------------------------------------------------------------------------
module rsdc_dp
   import rsdc_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [2:0]  req_func,
   input  logic [5:0]  req_step,
   input  logic [8:0]  req_drift,
   input  logic [8:0]  req_threshold,
   input  logic [31:0] req_new_seed,
   input  logic [5:0]  cfg_len,
   input  logic [53:0] cfg_lvl,
   input  logic [31:0] cfg_dseed,
   input  logic [31:0] cfg_pxor,
   output logic [31:0] chosen_seed,
   output logic        is_locked,
   output logic [8:0]  step_level,
   output logic [31:0] step_mask,
   output logic [31:0] pattern_seed_now,
   output logic [31:0] phrase_seed_now,
   output logic [31:0] phrase_count_now
);
   localparam int IW = $clog2(MAX_STEPS);

   logic [2:0]  func_ff;
   logic [5:0]  step_ff;
   logic [8:0]  drift_ff, thr_ff;
   logic [31:0] nseed_ff;
   logic [31:0] pat_ff, pat_in, phr_ff, phr_in, cnt_ff, cnt_in;
   logic        pend_ff, pend_in;
   logic [31:0] acc_ff, acc_in, prod_ff, prod_in;
   logic [31:0] chosen_ff, chosen_in;
   logic        locked_ff, locked_in;
   logic [8:0]  level_ff, level_in;
   logic [MAX_STEPS-1:0] mask_ff, mask_in;
   logic [IW-1:0] idx_ff, idx_in;

   logic [10:0] quo;
   logic        div_done;
   logic [5:0]  div_step, lim;
   logic [31:0] mul_a, mul_b, t1, t3, seed_init;
   logic        offbeat;
   logic [8:0]  lvl_q, lvl_m;

   assign div_step = (func_ff == FN_MASK) ? 6'(idx_ff) : step_ff;
   assign lim = (cfg_len < 6'(MAX_STEPS)) ? cfg_len : 6'(MAX_STEPS);

   rsdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIV),
      .dividend ({div_step, 5'd0}),
      .divisor  (cfg_len),
      .quotient (quo),
      .done     (div_done)
   );

   assign offbeat   = (cfg_len == 6'd0) || (step_ff >= cfg_len);
   assign lvl_q     = level_sel(cfg_lvl, offbeat ? CL_OFF : class_of(quo[4:0]));
   assign lvl_m     = level_sel(cfg_lvl, class_of(quo[4:0]));
   assign t1        = pat_ff ^ prod_ff;
   assign t3        = prod_ff ^ (prod_ff >> 16);
   assign seed_init = (nseed_ff == 32'd0) ? cfg_dseed : nseed_ff;

   always_comb begin
      unique case (cmd.op)
         OP_MULC: begin mul_a = cnt_ff; mul_b = GOLDEN;   end
         OP_MUL1: begin mul_a = acc_ff; mul_b = MIX_MUL1; end
         default: begin mul_a = acc_ff; mul_b = MIX_MUL2; end
      endcase
   end

   always_comb begin
      pat_in    = pat_ff;
      phr_in    = phr_ff;
      cnt_in    = cnt_ff;
      pend_in   = pend_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      chosen_in = chosen_ff;
      locked_in = locked_ff;
      level_in  = level_ff;
      mask_in   = mask_ff;
      idx_in    = idx_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            chosen_in = '0;
            locked_in = 1'b0;
            level_in  = '0;
            mask_in   = '0;
            idx_in    = '0;
         end
         OP_QFIN: begin
            level_in  = lvl_q;
            locked_in = lvl_q > drift_ff;
            chosen_in = (lvl_q > drift_ff) ? pat_ff : phr_ff;
         end
         OP_MBIT: begin
            if (lvl_m >= thr_ff) mask_in[idx_ff] = 1'b1;
            idx_in = IW'(idx_ff + 1'b1);
         end
         OP_MULC, OP_MUL1, OP_MUL2: prod_in = 32'(mul_a * mul_b);
         OP_MIX1: acc_in = t1 ^ (t1 >> 16);
         OP_MIX2: acc_in = prod_ff ^ (prod_ff >> 13);
         OP_MIX3: acc_in = (t3 == 32'd0) ? cfg_dseed : t3;
         OP_PEA: begin
            if (pend_ff) pat_in = acc_ff;
            pend_in = 1'b0;
            cnt_in  = cnt_ff + 32'd1;
         end
         OP_RSA: begin
            pat_in  = (nseed_ff == 32'd0) ? acc_ff : nseed_ff;
            cnt_in  = '0;
            pend_in = 1'b0;
         end
         OP_COMB: phr_in = pat_ff ^ (cnt_ff + GOLDEN + (pat_ff << 6) + (pat_ff >> 2));
         OP_REQ:  pend_in = 1'b1;
         OP_INIT: begin
            pat_in  = seed_init;
            phr_in  = seed_init ^ cfg_pxor;
            cnt_in  = '0;
            pend_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         func_ff  <= req_func;
         step_ff  <= req_step;
         drift_ff <= req_drift;
         thr_ff   <= req_threshold;
         nseed_ff <= req_new_seed;
      end
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      chosen_ff <= chosen_in;
      locked_ff <= locked_in;
      level_ff  <= level_in;
      mask_ff   <= mask_in;
      idx_ff    <= idx_in;
      if (reset) begin
         pat_ff  <= DSEED_RST;
         phr_ff  <= DSEED_RST ^ PXOR_RST;
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         pat_ff  <= pat_in;
         phr_ff  <= phr_in;
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   assign stat.func       = func_ff;
   assign stat.pending    = pend_ff;
   assign stat.nseed_zero = (nseed_ff == 32'd0);
   assign stat.div_done   = div_done;
   assign stat.mask_last  = ({{(6 - IW){1'b0}}, idx_ff} == 6'(lim - 6'd1));
   assign stat.mask_empty = (lim == 6'd0);

   assign chosen_seed      = chosen_ff;
   assign is_locked        = locked_ff;
   assign step_level       = level_ff;
   assign step_mask        = 32'(mask_ff);
   assign pattern_seed_now = pat_ff;
   assign phrase_seed_now  = phr_ff;
   assign phrase_count_now = cnt_ff;

endmodule

// ===== hw/rtl/rsdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsdc_ctrl
// Sequencer that walks each operation through the datapath.
// ----------------------------------------------------------------------------
`include "rhythm_seed_drift_control_core_defines.svh"
module rsdc_ctrl
   import rsdc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     out_free,
   output logic     out_load,
   input  stat_type stat,
   output cmd_type  cmd
);
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DEC   = 5'd1;
   localparam logic [4:0] S_QDIV  = 5'd2;
   localparam logic [4:0] S_QFIN  = 5'd3;
   localparam logic [4:0] S_MDIV  = 5'd4;
   localparam logic [4:0] S_MBIT  = 5'd5;
   localparam logic [4:0] S_MSTA  = 5'd6;
   localparam logic [4:0] S_M1    = 5'd7;
   localparam logic [4:0] S_M2    = 5'd8;
   localparam logic [4:0] S_M3    = 5'd9;
   localparam logic [4:0] S_M4    = 5'd10;
   localparam logic [4:0] S_M5    = 5'd11;
   localparam logic [4:0] S_PEA   = 5'd12;
   localparam logic [4:0] S_RSA   = 5'd13;
   localparam logic [4:0] S_COMB  = 5'd14;
   localparam logic [4:0] S_DONE  = 5'd15;

   logic [4:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            cmd.op   = OP_LOAD;
            state_in = S_DEC;
         end
         S_DEC: begin
            case (stat.func)
               FN_QUERY: begin cmd.op = OP_DIV; state_in = S_QDIV; end
               FN_PEND: begin
                  if (stat.pending) begin cmd.op = OP_MULC; state_in = S_M1; end
                  else state_in = S_PEA;
               end
               FN_REQ: begin cmd.op = OP_REQ; state_in = S_DONE; end
               FN_RESEED: begin
                  if (stat.nseed_zero) begin cmd.op = OP_MULC; state_in = S_M1; end
                  else state_in = S_RSA;
               end
               FN_INIT: begin cmd.op = OP_INIT; state_in = S_DONE; end
               FN_MASK: begin
                  if (stat.mask_empty) state_in = S_DONE;
                  else begin cmd.op = OP_DIV; state_in = S_MDIV; end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_QDIV: if (stat.div_done) state_in = S_QFIN;
         S_QFIN: begin cmd.op = OP_QFIN; state_in = S_DONE; end
         S_MDIV: if (stat.div_done) state_in = S_MBIT;
         S_MBIT: begin
            cmd.op   = OP_MBIT;
            state_in = stat.mask_last ? S_DONE : S_MSTA;
         end
         S_MSTA: begin cmd.op = OP_DIV;  state_in = S_MDIV; end
         S_M1:   begin cmd.op = OP_MIX1; state_in = S_M2; end
         S_M2:   begin cmd.op = OP_MUL1; state_in = S_M3; end
         S_M3:   begin cmd.op = OP_MIX2; state_in = S_M4; end
         S_M4:   begin cmd.op = OP_MUL2; state_in = S_M5; end
         S_M5: begin
            cmd.op   = OP_MIX3;
            state_in = (stat.func == FN_PEND) ? S_PEA : S_RSA;
         end
         S_PEA:  begin cmd.op = OP_PEA;  state_in = S_COMB; end
         S_RSA:  begin cmd.op = OP_RSA;  state_in = S_COMB; end
         S_COMB: begin cmd.op = OP_COMB; state_in = S_DONE; end
         S_DONE: if (out_free) begin
            out_load = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   `RSDC_ASSERT_NXT(a_accept_dec, clock, reset, accept, state_ff == S_DEC)
   `RSDC_ASSERT_NXT(a_done_idle, clock, reset, out_load, state_ff == S_IDLE)
   `RSDC_ASSERT_NXT(a_qdiv_wait, clock, reset, (state_ff == S_QDIV) && !stat.div_done, state_ff == S_QDIV)
   `RSDC_ASSERT_IMP(a_load_done, clock, reset, out_load, (state_ff == S_DONE) && out_free)

endmodule

// ===== hw/rtl/rhythm_seed_drift_control_core.sv =====
// ----------------------------------------------------------------------------
// rhythm_seed_drift_control_core
// Seed drift control for a rhythm sequencer: register file, output beat stage.
// ----------------------------------------------------------------------------
// Step query: the result waits on the bit-serial divider.
// Seed ops: the mixer runs through one shared registered multiplier.
// Mask: one divide per step, for min(length, MAX_STEPS) steps.
// One item in flight; the next beat is taken while a result waits on rsp_stall.
// Synchronous reset restores register defaults and seed state; no clearing pass.
module rhythm_seed_drift_control_core
   import rsdc_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [5:0]  req_step,
   input  logic [8:0]  req_drift,
   input  logic [8:0]  req_threshold,
   input  logic [31:0] req_new_seed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_chosen_seed,
   output logic        rsp_is_locked,
   output logic [8:0]  rsp_step_level,
   output logic [31:0] rsp_step_mask,
   output logic [31:0] rsp_pattern_seed_now,
   output logic [31:0] rsp_phrase_seed_now,
   output logic [31:0] rsp_phrase_count_now,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   logic [5:0]  len_ff;
   logic [53:0] lvl_ff;
   logic [31:0] dseed_ff, pxor_ff;
   logic        wr;

   cmd_type  cmd;
   stat_type stat;
   logic     out_free, out_load;

   logic [31:0] d_chosen, d_mask, d_pat, d_phr, d_cnt;
   logic        d_locked;
   logic [8:0]  d_level;

   logic        rv_ff, rv_in;
   logic [31:0] o_chosen_ff, o_mask_ff, o_pat_ff, o_phr_ff, o_cnt_ff;
   logic        o_locked_ff;
   logic [8:0]  o_level_ff;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LEN_RST;
         lvl_ff   <= LVL_RST;
         dseed_ff <= DSEED_RST;
         pxor_ff  <= PXOR_RST;
      end else if (wr) begin
         unique case (paddr[4:3])
            REG_LEN:   len_ff   <= pwdata[5:0];
            REG_LVL:   lvl_ff   <= pwdata[53:0];
            REG_DSEED: dseed_ff <= pwdata[31:0];
            default:   pxor_ff  <= pwdata[31:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         REG_LEN:   prdata = 64'(len_ff);
         REG_LVL:   prdata = 64'(lvl_ff);
         REG_DSEED: prdata = 64'(dseed_ff);
         default:   prdata = 64'(pxor_ff);
      endcase
   end

   rsdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .out_load  (out_load),
      .stat      (stat),
      .cmd       (cmd)
   );

   rsdc_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_step         (req_step),
      .req_drift        (req_drift),
      .req_threshold    (req_threshold),
      .req_new_seed     (req_new_seed),
      .cfg_len          (len_ff),
      .cfg_lvl          (lvl_ff),
      .cfg_dseed        (dseed_ff),
      .cfg_pxor         (pxor_ff),
      .chosen_seed      (d_chosen),
      .is_locked        (d_locked),
      .step_level       (d_level),
      .step_mask        (d_mask),
      .pattern_seed_now (d_pat),
      .phrase_seed_now  (d_phr),
      .phrase_count_now (d_cnt)
   );

   assign out_free = !rv_ff || !rsp_stall;

   always_comb begin
      rv_in = rv_ff;
      if (out_load)        rv_in = 1'b1;
      else if (!rsp_stall) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_chosen_ff <= d_chosen;
         o_locked_ff <= d_locked;
         o_level_ff  <= d_level;
         o_mask_ff   <= d_mask;
         o_pat_ff    <= d_pat;
         o_phr_ff    <= d_phr;
         o_cnt_ff    <= d_cnt;
      end
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= rv_in;
   end

   assign rsp_valid            = rv_ff;
   assign rsp_chosen_seed      = o_chosen_ff;
   assign rsp_is_locked        = o_locked_ff;
   assign rsp_step_level       = o_level_ff;
   assign rsp_step_mask        = o_mask_ff;
   assign rsp_pattern_seed_now = o_pat_ff;
   assign rsp_phrase_seed_now  = o_phr_ff;
   assign rsp_phrase_count_now = o_cnt_ff;

endmodule

// ===== test/tb_rhythm_seed_drift_control_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rhythm_seed_drift_control_core
// Self-checking bench: directed table then random operations under random result
// stalls and request gaps, each result beat checked against a seed model or table entry.
// ----------------------------------------------------------------------------
module tb_rhythm_seed_drift_control_core;
   import rsdc_pkg::*;

   localparam logic [2:0] FN_READ  = 3'd6;
   localparam logic [2:0] FN_SPARE = 3'd7;
   localparam int LIMIT = 2000000;
   localparam int N_PRE = 6;

   typedef struct packed {
      logic [2:0]  func;
      logic [5:0]  step;
      logic [8:0]  drift;
      logic [8:0]  threshold;
      logic [31:0] new_seed;
   } op_beat_type;

   typedef struct packed {
      logic [31:0] chosen_seed;
      logic        is_locked;
      logic [8:0]  step_level;
      logic [31:0] step_mask;
      logic [31:0] pattern_seed_now;
      logic [31:0] phrase_seed_now;
      logic [31:0] phrase_count_now;
   } seed_beat_type;

   typedef struct {
      op_beat_type   op;
      bit            fixed;
      seed_beat_type res;
   } table_row_type;

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, req_stall;
   logic [2:0]  req_func = 0;
   logic [5:0]  req_step = 0;
   logic [8:0]  req_drift = 0, req_threshold = 0;
   logic [31:0] req_new_seed = 0;
   logic        rsp_valid, rsp_stall = 0;
   logic [31:0] rsp_chosen_seed, rsp_step_mask;
   logic        rsp_is_locked;
   logic [8:0]  rsp_step_level;
   logic [31:0] rsp_pattern_seed_now, rsp_phrase_seed_now, rsp_phrase_count_now;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [4:0]  paddr = 0;
   logic [63:0] pwdata = 0, prdata;
   logic        pready;

   rhythm_seed_drift_control_core dut (.*);

   // model configuration and state
   logic [5:0]  len_q = LEN_RST;
   logic [53:0] lvl_q = LVL_RST;
   logic [31:0] dseed_q = DSEED_RST, pxor_q = PXOR_RST;
   logic [31:0] pat_seed = DSEED_RST, phr_seed = DSEED_RST ^ PXOR_RST, phr_count = 0;
   bit          pending = 0;

   seed_beat_type pending_beats[$];
   int  errors = 0, cycles = 0, stall_left = 0;
   bit  calm = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [8:0] class_level(logic [2:0] cls);
      return lvl_q[cls*9 +: 9];
   endfunction

   function automatic logic [8:0] grid_level(logic [5:0] st);
      int n;
      if (len_q == 0 || st >= len_q) return class_level(CL_OFF);
      n = (st * 32) / len_q;
      if (n == 0) return class_level(CL_DOWN);
      if (n == 16) return class_level(CL_HALF);
      if (n == 8 || n == 24) return class_level(CL_QTR);
      if (n % 8 == 4) return class_level(CL_8TH);
      if (n % 2 == 0) return class_level(CL_16TH);
      return class_level(CL_OFF);
   endfunction

   function automatic logic [31:0] murmur_mix(logic [31:0] cur, logic [31:0] cnt);
      logic [31:0] s;
      s = cur ^ (cnt * GOLDEN);
      s = s ^ (s >> 16);
      s = s * MIX_MUL1;
      s = s ^ (s >> 13);
      s = s * MIX_MUL2;
      s = s ^ (s >> 16);
      return (s == 0) ? dseed_q : s;
   endfunction

   function automatic logic [31:0] hash_combine(logic [31:0] sd, logic [31:0] v);
      return sd ^ (v + GOLDEN + (sd << 6) + (sd >> 2));
   endfunction

   function automatic seed_beat_type run_seed_op(op_beat_type b);
      seed_beat_type r;
      int lim;
      r = '0;
      case (b.func)
         FN_QUERY: begin
            r.step_level = grid_level(b.step);
            r.is_locked = r.step_level > b.drift;
            r.chosen_seed = r.is_locked ? pat_seed : phr_seed;
         end
         FN_PEND: begin
            if (pending) begin
               pat_seed = murmur_mix(pat_seed, phr_count);
               pending = 0;
            end
            phr_count = phr_count + 1;
            phr_seed = hash_combine(pat_seed, phr_count);
         end
         FN_REQ: pending = 1;
         FN_RESEED: begin
            pat_seed = (b.new_seed == 0) ? murmur_mix(pat_seed, phr_count) : b.new_seed;
            phr_count = 0;
            phr_seed = hash_combine(pat_seed, 0);
            pending = 0;
         end
         FN_INIT: begin
            pat_seed = (b.new_seed == 0) ? dseed_q : b.new_seed;
            phr_seed = pat_seed ^ pxor_q;
            phr_count = 0;
            pending = 0;
         end
         FN_MASK: begin
            lim = (len_q < 32) ? len_q : 32;
            for (int s = 0; s < lim; s++)
               if (grid_level(s) >= b.threshold) r.step_mask[s] = 1'b1;
         end
         default: ;
      endcase
      r.pattern_seed_now = pat_seed;
      r.phrase_seed_now = phr_seed;
      r.phrase_count_now = phr_count;
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      seed_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $error("result beat with no expectation");
            errors++;
         end else begin
            e = pending_beats.pop_front();
            if (rsp_chosen_seed !== e.chosen_seed) begin
               $error("chosen_seed exp %h got %h", e.chosen_seed, rsp_chosen_seed);
               errors++;
            end
            if (rsp_is_locked !== e.is_locked) begin
               $error("is_locked exp %b got %b", e.is_locked, rsp_is_locked);
               errors++;
            end
            if (rsp_step_level !== e.step_level) begin
               $error("step_level exp %h got %h", e.step_level, rsp_step_level);
               errors++;
            end
            if (rsp_step_mask !== e.step_mask) begin
               $error("step_mask exp %h got %h", e.step_mask, rsp_step_mask);
               errors++;
            end
            if (rsp_pattern_seed_now !== e.pattern_seed_now) begin
               $error("pattern_seed_now exp %h got %h", e.pattern_seed_now,
                      rsp_pattern_seed_now);
               errors++;
            end
            if (rsp_phrase_seed_now !== e.phrase_seed_now) begin
               $error("phrase_seed_now exp %h got %h", e.phrase_seed_now,
                      rsp_phrase_seed_now);
               errors++;
            end
            if (rsp_phrase_count_now !== e.phrase_count_now) begin
               $error("phrase_count_now exp %h got %h", e.phrase_count_now,
                      rsp_phrase_count_now);
               errors++;
            end
         end
      end
   end

   // result-side stall bursts
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left--;
      end else begin
         rsp_stall <= 0;
         if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 7);
      end
   end

   task automatic send_op(op_beat_type b, bit fixed, seed_beat_type want);
      seed_beat_type got;
      @(negedge clock);
      req_func <= b.func;
      req_step <= b.step;
      req_drift <= b.drift;
      req_threshold <= b.threshold;
      req_new_seed <= b.new_seed;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = run_seed_op(b);
      pending_beats.push_back(fixed ? want : got);
      if (!calm && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [63:0] v);
      @(negedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 3'b000};
      pwdata <= v;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      case (idx)
         REG_LEN:   len_q = v[5:0];
         REG_LVL:   lvl_q = v[53:0];
         REG_DSEED: dseed_q = v[31:0];
         default:   pxor_q = v[31:0];
      endcase
   endtask

   task automatic csr_all(logic [5:0] l, logic [53:0] lv, logic [31:0] ds, logic [31:0] px);
      csr_write(REG_LEN, 64'(l));
      csr_write(REG_LVL, 64'(lv));
      csr_write(REG_DSEED, 64'(ds));
      csr_write(REG_PXOR, 64'(px));
   endtask

   function automatic op_beat_type mk(logic [2:0] f, logic [5:0] st, logic [8:0] d,
                                      logic [8:0] t, logic [31:0] sd);
      op_beat_type b;
      b.func = f; b.step = st; b.drift = d; b.threshold = t; b.new_seed = sd;
      return b;
   endfunction

   function automatic seed_beat_type fx(logic [31:0] ch, logic [31:0] mask,
                                        logic [31:0] ps, logic [31:0] hs, logic [31:0] pc);
      seed_beat_type r;
      r = '0;
      r.chosen_seed = ch; r.step_mask = mask;
      r.pattern_seed_now = ps; r.phrase_seed_now = hs; r.phrase_count_now = pc;
      return r;
   endfunction

   function automatic op_beat_type rand_op();
      op_beat_type b;
      int w;
      w = $urandom_range(0, 99);
      if (w < 40)      b.func = FN_QUERY;
      else if (w < 55) b.func = FN_PEND;
      else if (w < 65) b.func = FN_REQ;
      else if (w < 73) b.func = FN_RESEED;
      else if (w < 79) b.func = FN_INIT;
      else if (w < 91) b.func = FN_MASK;
      else if (w < 96) b.func = FN_READ;
      else             b.func = FN_SPARE;
      b.step = $urandom_range(0, 63);
      b.drift = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                            : 9'($urandom_range(0, 256));
      b.threshold = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                : 9'($urandom_range(0, 256));
      b.new_seed = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
      return b;
   endfunction

   table_row_type plan[25] = '{
      '{mk(FN_READ, 0, 0, 0, 0), 1, fx(0, 0, 1, 1, 0)},
      '{mk(FN_QUERY, 0, 0, 0, 0), 1, fx(1, 0, 1, 1, 0)},
      '{mk(FN_MASK, 0, 0, 0, 0), 1, fx(0, 32'hffffffff, 1, 1, 0)},
      '{mk(FN_MASK, 0, 0, 9'h1ff, 0), 1, fx(0, 0, 1, 1, 0)},
      '{mk(FN_SPARE, 63, 9'h1ff, 9'h1ff, 32'hffffffff), 1, fx(0, 0, 1, 1, 0)},
      '{mk(FN_INIT, 0, 0, 0, 0), 1, fx(0, 0, 1, 1, 0)},
      '{mk(FN_QUERY, 0, 0, 0, 0), 0, '0},
      '{mk(FN_QUERY, 16, 9'd255, 0, 0), 0, '0},
      '{mk(FN_QUERY, 8, 9'd256, 0, 0), 0, '0},
      '{mk(FN_QUERY, 4, 9'h1ff, 0, 0), 0, '0},
      '{mk(FN_QUERY, 2, 9'd100, 0, 0), 0, '0},
      '{mk(FN_QUERY, 1, 0, 0, 0), 0, '0},
      '{mk(FN_QUERY, 63, 0, 0, 0), 0, '0},
      '{mk(FN_REQ, 0, 0, 0, 0), 0, '0},
      '{mk(FN_PEND, 0, 0, 0, 0), 0, '0},
      '{mk(FN_PEND, 0, 0, 0, 0), 0, '0},
      '{mk(FN_RESEED, 0, 0, 0, 0), 0, '0},
      '{mk(FN_RESEED, 0, 0, 0, 32'hffffffff), 0, '0},
      '{mk(FN_INIT, 0, 0, 0, 32'hffffffff), 0, '0},
      '{mk(FN_MASK, 0, 0, 9'd128, 0), 0, '0},
      '{mk(FN_MASK, 0, 0, 9'd256, 0), 0, '0},
      '{mk(FN_INIT, 0, 0, 0, 0), 0, '0},
      '{mk(FN_RESEED, 0, 0, 0, 0), 0, '0},
      '{mk(FN_QUERY, 5, 9'd10, 0, 0), 0, '0},
      '{mk(FN_MASK, 0, 0, 0, 0), 0, '0}
   };

   initial begin
      logic [5:0] l;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      for (int i = 0; i < N_PRE; i++) send_op(plan[i].op, plan[i].fixed, plan[i].res);
      drain();
      // distinct levels, one above full scale; offbeat highest
      csr_all(6'd32, {9'h1ff, 9'd32, 9'd64, 9'd128, 9'd200, 9'd256}, 32'h0, 32'h5a5a5a5a);
      for (int i = N_PRE; i < $size(plan); i++) begin
         if (i == 21) begin
            drain();
            csr_write(REG_LEN, 64'd0);
         end
         send_op(plan[i].op, plan[i].fixed, plan[i].res);
      end
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: l = 6'd1;
            1: l = 6'd63;
            2: l = 6'd0;
            3: l = 6'd32;
            default: l = 6'($urandom_range(1, 40));
         endcase
         csr_all(l, (ph == 1) ? 54'h3fffffffffffff : 54'({$urandom, $urandom}),
                 (ph == 2) ? 32'h0 : ((ph == 1) ? 32'hffffffff : $urandom),
                 (ph == 3) ? 32'hffffffff : $urandom);
         calm = (ph == 8);
         for (int k = 0; k < 85; k++) send_op(rand_op(), 0, '0);
         drain();
      end

      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
